/* hdl/tvg_pkg.sv */
// shared types and constants for the thrust vector to gimbal command pipeline
// no dependencies
package tvg_pkg;

  localparam int F_W          = 24;  // force and coefficient width
  localparam int CMD_W        = 16;
  localparam int SQ_W         = 64;  // square root operand width
  localparam int SQRT_STEPS   = 32;
  localparam int CV_W         = 44;  // cordic vector width
  localparam int ANG_W        = 34;  // cordic angle width, full turn = 2^32
  localparam int CORDIC_STEPS = 30;
  localparam int DV_W         = 47;  // divider remainder width
  localparam int DIV_STEPS    = 16;

  localparam logic signed [ANG_W-1:0] QUARTER_TURN = ANG_W'(64'sd1073741824);
  localparam logic signed [CMD_W-1:0] CMD_MAX      = 16'sh7FFF;
  localparam logic signed [CMD_W-1:0] CMD_MIN      = 16'sh8000;
  localparam logic signed [CMD_W-1:0] CMD_ONE      = 16'sd16384;
  localparam logic signed [CMD_W-1:0] OUTER_FLOOR  = -16'sd492;
  localparam logic [CMD_W-1:0]        THRUST_MAX   = 16'hFFFF;
  localparam logic [F_W-1:0]          COEF_RESET   = 24'd65536;

  typedef enum logic [1:0] {
    REG_COEF0 = 2'd0,
    REG_COEF1 = 2'd1,
    REG_COEF2 = 2'd2,
    REG_COEF3 = 2'd3
  } reg_idx_t;

  // atan(2^-i) in units of 2^-32 turn
  localparam logic [31:0] STEP_ANGLE [CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
  };

  typedef struct packed {
    logic signed [CV_W-1:0]  x;
    logic signed [CV_W-1:0]  y;
    logic signed [ANG_W-1:0] ang;
  } cvec_t;

endpackage

/* hdl/tvg_sqrt_cell.sv */
// one result bit of the digit-by-digit integer square root
// depends on tvg_pkg
module tvg_sqrt_cell
  import tvg_pkg::*;
#(
  parameter int P = 0
) (
  input  logic            clk,
  input  logic            en,
  input  logic [SQ_W-1:0] v_in,
  input  logic [SQ_W-1:0] r_in,
  output logic [SQ_W-1:0] v_out,
  output logic [SQ_W-1:0] r_out
);

  localparam logic [SQ_W-1:0] B = {{(SQ_W-1){1'b0}}, 1'b1} << (2 * P);

  logic [SQ_W-1:0] trial;
  logic [SQ_W:0]   diff;
  logic [SQ_W-1:0] v_nxt, r_nxt;
  logic [SQ_W-1:0] v_r, r_r;

  always_comb begin
    trial = r_in + B;
    diff  = {1'b0, v_in} - {1'b0, trial};
    if (!diff[SQ_W]) begin
      v_nxt = diff[SQ_W-1:0];
      r_nxt = (r_in >> 1) + B;
    end else begin
      v_nxt = v_in;
      r_nxt = r_in >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v_r <= v_nxt;
      r_r <= r_nxt;
    end
  end

  assign v_out = v_r;
  assign r_out = r_r;

endmodule

/* hdl/tvg_div_cell.sv */
// one quotient bit of the restoring thrust divider
// depends on tvg_pkg
module tvg_div_cell
  import tvg_pkg::*;
#(
  parameter int K = 0
) (
  input  logic             clk,
  input  logic             en,
  input  logic [DV_W-1:0]  rem_in,
  input  logic [F_W-1:0]   coef_in,
  input  logic [CMD_W-1:0] q_in,
  output logic [DV_W-1:0]  rem_out,
  output logic [F_W-1:0]   coef_out,
  output logic [CMD_W-1:0] q_out
);

  logic [DV_W-1:0]  sub;
  logic [DV_W:0]    diff;
  logic [DV_W-1:0]  rem_nxt;
  logic [CMD_W-1:0] q_nxt;
  logic [DV_W-1:0]  rem_r;
  logic [F_W-1:0]   coef_r;
  logic [CMD_W-1:0] q_r;

  always_comb begin
    sub     = DV_W'(coef_in) << K;
    diff    = {1'b0, rem_in} - {1'b0, sub};
    rem_nxt = rem_in;
    q_nxt   = q_in;
    if (!diff[DV_W]) begin
      rem_nxt  = diff[DV_W-1:0];
      q_nxt[K] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= rem_nxt;
      coef_r <= coef_in;
      q_r    <= q_nxt;
    end
  end

  assign rem_out  = rem_r;
  assign coef_out = coef_r;
  assign q_out    = q_r;

endmodule

/* hdl/tvg_cordic_cell.sv */
// one micro-rotation of the vectoring cordic
// depends on tvg_pkg
module tvg_cordic_cell
  import tvg_pkg::*;
#(
  parameter int I = 0
) (
  input  logic  clk,
  input  logic  en,
  input  cvec_t v_in,
  output cvec_t v_out
);

  localparam logic signed [ANG_W-1:0] A = ANG_W'(STEP_ANGLE[I]);

  logic signed [CV_W-1:0] dx, dy;
  cvec_t v_nxt, v_r;

  always_comb begin
    dx = v_in.x >>> I;
    dy = v_in.y >>> I;
    if (v_in.y > 0) begin
      v_nxt.x   = v_in.x + dy;
      v_nxt.y   = v_in.y - dx;
      v_nxt.ang = v_in.ang + A;
    end else begin
      v_nxt.x   = v_in.x - dy;
      v_nxt.y   = v_in.y + dx;
      v_nxt.ang = v_in.ang - A;
    end
  end

  always_ff @(posedge clk) begin
    if (en) v_r <= v_nxt;
  end

  assign v_out = v_r;

endmodule

/* hdl/thrust_vector_to_gimbal_commands_top.sv */
// throughput: one word per cycle; the whole cell chain advances together and
// holds while a finished result waits on out_tready
// stages: capture, square, sum, 32 square root cells, pre-rotation, 30 cordic cells
// with the 16 divider cells beside them, output register
// reset (rst_n low, synchronous) empties the pipeline and sets all coefficients to 1.0
module thrust_vector_to_gimbal_commands_top
  import tvg_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // force_x, force_y, force_z
  input  logic [1:0]  in_tuser,   // rotor
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // thrust_cmd, inner_cmd, outer_cmd
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  localparam int N_STG = 3 + SQRT_STEPS + 1 + CORDIC_STEPS + 1;
  localparam int T_DLY = CORDIC_STEPS - DIV_STEPS;

  typedef struct packed {
    logic signed [F_W-1:0] x;
    logic signed [F_W-1:0] z;
    logic [F_W-1:0]        coef;
    logic                  yz_zero;
  } sb_t;

  typedef struct packed {
    logic yz_zero;
    logic x_pos;
    logic sat;
  } flg_t;

  logic             en;
  logic [N_STG-1:0] vld_r;
  logic [F_W-1:0]   coef_r [4];

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) coef_r[i] <= COEF_RESET;
    end else if (cfg_wr_en) begin
      unique case (reg_idx_t'(cfg_index))
        REG_COEF0: coef_r[0] <= cfg_data;
        REG_COEF1: coef_r[1] <= cfg_data;
        REG_COEF2: coef_r[2] <= cfg_data;
        REG_COEF3: coef_r[3] <= cfg_data;
        default:   coef_r[0] <= coef_r[0];
      endcase
    end
  end

  assign en        = !vld_r[N_STG-1] || out_tready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[N_STG-2:0], in_tvalid};
    end
  end

  // stage a: capture, clamp x, pick coefficient
  logic signed [F_W-1:0] in_x, in_y, in_z;
  logic signed [F_W-1:0] a_x_r, a_y_r, a_z_r;
  logic [F_W-1:0]        a_coef_r;

  assign in_x = in_tdata[23:0];
  assign in_y = in_tdata[47:24];
  assign in_z = in_tdata[71:48];

  always_ff @(posedge clk) begin
    if (en) begin
      a_x_r    <= in_x[F_W-1] ? '0 : in_x;
      a_y_r    <= in_y;
      a_z_r    <= in_z;
      a_coef_r <= coef_r[in_tuser];
    end
  end

  // stage b: squares
  logic signed [47:0]    sq_x, sq_y, sq_z;
  logic [46:0]           b_xx_r, b_yy_r, b_zz_r;
  logic signed [F_W-1:0] b_x_r, b_z_r;
  logic [F_W-1:0]        b_coef_r;

  assign sq_x = a_x_r * a_x_r;
  assign sq_y = a_y_r * a_y_r;
  assign sq_z = a_z_r * a_z_r;

  always_ff @(posedge clk) begin
    if (en) begin
      b_xx_r   <= sq_x[46:0];
      b_yy_r   <= sq_y[46:0];
      b_zz_r   <= sq_z[46:0];
      b_x_r    <= a_x_r;
      b_z_r    <= a_z_r;
      b_coef_r <= a_coef_r;
    end
  end

  // stage c: sums, shifted into root operands
  logic [47:0]     sum_yz, sum_all;
  logic [SQ_W-1:0] c_s_r, c_syz_r;
  sb_t             c_sb_r;
  logic signed [F_W-1:0] c_y_r;

  assign sum_yz  = 48'(b_yy_r) + 48'(b_zz_r);
  assign sum_all = sum_yz + 48'(b_xx_r);

  always_ff @(posedge clk) begin
    if (en) begin
      c_s_r          <= {sum_all, 16'b0};
      c_syz_r        <= {sum_yz, 16'b0};
      c_sb_r.x       <= b_x_r;
      c_sb_r.z       <= b_z_r;
      c_sb_r.coef    <= b_coef_r;
      c_sb_r.yz_zero <= (sum_yz == '0);
    end
  end

  // y is recovered after the roots from a parallel delay line
  logic signed [F_W-1:0] y_dly_r [SQRT_STEPS+2];
  always_ff @(posedge clk) begin
    if (en) begin
      y_dly_r[0] <= a_y_r;
      for (int k = 1; k < SQRT_STEPS + 2; k++) y_dly_r[k] <= y_dly_r[k-1];
    end
  end
  assign c_y_r = y_dly_r[SQRT_STEPS+1];

  // square root chains
  logic [SQ_W-1:0] ss_v [SQRT_STEPS+1];
  logic [SQ_W-1:0] ss_r [SQRT_STEPS+1];
  logic [SQ_W-1:0] sy_v [SQRT_STEPS+1];
  logic [SQ_W-1:0] sy_r [SQRT_STEPS+1];

  assign ss_v[0] = c_s_r;
  assign ss_r[0] = '0;
  assign sy_v[0] = c_syz_r;
  assign sy_r[0] = '0;

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    tvg_sqrt_cell #(.P(SQRT_STEPS - 1 - k)) u_len (
      .clk(clk), .en(en),
      .v_in(ss_v[k]), .r_in(ss_r[k]), .v_out(ss_v[k+1]), .r_out(ss_r[k+1])
    );
    tvg_sqrt_cell #(.P(SQRT_STEPS - 1 - k)) u_ryz (
      .clk(clk), .en(en),
      .v_in(sy_v[k]), .r_in(sy_r[k]), .v_out(sy_v[k+1]), .r_out(sy_r[k+1])
    );
  end

  sb_t sb_r [SQRT_STEPS];
  always_ff @(posedge clk) begin
    if (en) begin
      sb_r[0] <= c_sb_r;
      for (int k = 1; k < SQRT_STEPS; k++) sb_r[k] <= sb_r[k-1];
    end
  end

  // stage p: cordic pre-rotation and divider setup
  function automatic cvec_t pre_rot(logic signed [CV_W-1:0] xv, logic signed [CV_W-1:0] yv);
    cvec_t o;
    o.x   = xv;
    o.y   = yv;
    o.ang = '0;
    if (xv < 0) begin
      if (yv >= 0) begin
        o.x   = yv;
        o.y   = -xv;
        o.ang = QUARTER_TURN;
      end else begin
        o.x   = -yv;
        o.y   = xv;
        o.ang = -QUARTER_TURN;
      end
    end
    return o;
  endfunction

  sb_t                    sb_end;
  logic [31:0]            len_q, ryz_q;
  logic signed [CV_W-1:0] nz_v, y_v, r_v, x_v;
  cvec_t                  p_in_r, p_out_r;
  logic [DV_W-1:0]        p_rem_r;
  logic [F_W-1:0]         p_coef_r;
  flg_t                   p_flg_r;

  assign sb_end = sb_r[SQRT_STEPS-1];
  assign len_q  = ss_r[SQRT_STEPS][31:0];
  assign ryz_q  = sy_r[SQRT_STEPS][31:0];
  assign nz_v   = (-CV_W'(sb_end.z)) <<< 16;
  assign y_v    = CV_W'(c_y_r) <<< 16;
  assign r_v    = CV_W'({ryz_q, 8'b0});
  assign x_v    = CV_W'(sb_end.x) <<< 16;

  always_ff @(posedge clk) begin
    if (en) begin
      p_in_r          <= pre_rot(nz_v, y_v);
      p_out_r         <= pre_rot(r_v, x_v);
      p_rem_r         <= DV_W'({len_q, 15'b0});
      p_coef_r        <= sb_end.coef;
      // quotient would exceed 16 bits, also covers a zero coefficient
      p_flg_r.sat     <= 33'(len_q) >= 33'({sb_end.coef, 1'b0});
      p_flg_r.yz_zero <= sb_end.yz_zero;
      p_flg_r.x_pos   <= (sb_end.x != '0);
    end
  end

  // cordic chains
  cvec_t ci [CORDIC_STEPS+1];
  cvec_t co [CORDIC_STEPS+1];
  assign ci[0] = p_in_r;
  assign co[0] = p_out_r;

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
    tvg_cordic_cell #(.I(k)) u_in  (.clk(clk), .en(en), .v_in(ci[k]), .v_out(ci[k+1]));
    tvg_cordic_cell #(.I(k)) u_out (.clk(clk), .en(en), .v_in(co[k]), .v_out(co[k+1]));
  end

  // divider chain beside the first cordic cells
  logic [DV_W-1:0]  dv_rem [DIV_STEPS+1];
  logic [F_W-1:0]   dv_cf  [DIV_STEPS+1];
  logic [CMD_W-1:0] dv_q   [DIV_STEPS+1];
  assign dv_rem[0] = p_rem_r;
  assign dv_cf[0]  = p_coef_r;
  assign dv_q[0]   = '0;

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    tvg_div_cell #(.K(DIV_STEPS - 1 - k)) u_div (
      .clk(clk), .en(en),
      .rem_in(dv_rem[k]), .coef_in(dv_cf[k]), .q_in(dv_q[k]),
      .rem_out(dv_rem[k+1]), .coef_out(dv_cf[k+1]), .q_out(dv_q[k+1])
    );
  end

  logic [CMD_W-1:0] tq_r [T_DLY];
  flg_t             fl_r [CORDIC_STEPS];
  always_ff @(posedge clk) begin
    if (en) begin
      tq_r[0] <= dv_q[DIV_STEPS];
      for (int k = 1; k < T_DLY; k++) tq_r[k] <= tq_r[k-1];
      fl_r[0] <= p_flg_r;
      for (int k = 1; k < CORDIC_STEPS; k++) fl_r[k] <= fl_r[k-1];
    end
  end

  // stage o: angle to command, special cases
  function automatic logic signed [CMD_W-1:0] to_cmd(logic signed [ANG_W-1:0] ang);
    logic signed [ANG_W-1:0] t;
    logic signed [ANG_W-1:0] c;
    t = ang + ANG_W'(32768);
    c = t >>> 16;
    if (c > ANG_W'(CMD_MAX)) return CMD_MAX;
    if (c < ANG_W'(CMD_MIN)) return CMD_MIN;
    return c[CMD_W-1:0];
  endfunction

  flg_t                    fl_end;
  logic signed [CMD_W-1:0] in_cmd, out_cmd;
  logic [CMD_W-1:0]        o_thrust_r;
  logic signed [CMD_W-1:0] o_inner_r, o_outer_r;

  assign fl_end  = fl_r[CORDIC_STEPS-1];
  assign in_cmd  = to_cmd(ci[CORDIC_STEPS].ang);
  assign out_cmd = to_cmd(co[CORDIC_STEPS].ang);

  always_ff @(posedge clk) begin
    if (en) begin
      o_thrust_r <= fl_end.sat ? THRUST_MAX : tq_r[T_DLY-1];
      if (fl_end.yz_zero) begin
        o_inner_r <= CMD_MAX;
        o_outer_r <= fl_end.x_pos ? CMD_ONE : '0;
      end else begin
        o_inner_r <= in_cmd;
        o_outer_r <= (out_cmd < OUTER_FLOOR) ? OUTER_FLOOR : out_cmd;
      end
    end
  end

  assign out_tvalid = vld_r[N_STG-1];
  assign out_tdata  = {o_outer_r, o_inner_r, o_thrust_r};

`ifndef SYNTHESIS
  a_outer_floor : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> $signed(out_tdata[47:32]) >= OUTER_FLOOR)
    else $error("outer command below floor");

  a_stall_holds : assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_r))
    else $error("pipeline moved while stalled");

  a_accept_enters : assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> vld_r[0])
    else $error("accepted word lost at pipeline entry");
`endif

endmodule

/* test/tvg_checker.sv */
// checker for the thrust vector to gimbal command block: predicts each result word
// from the input words it sees accepted and compares it with the output words
// depends on tvg_pkg
module tvg_checker
  import tvg_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [71:0] in_tdata,
  input  logic [1:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [47:0] out_tdata,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data,
  output int          fail_count,
  output int          pending_cmds
);

  // first member sits in the top bits, so thrust comes last
  typedef struct packed {
    logic signed [15:0] outer;
    logic signed [15:0] inner;
    logic [15:0]        thrust;
  } gimbal_cmd_t;

  localparam longint ATAN_STEP [30] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
    64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
    64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
    64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
    64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051, 64'h00000029,
    64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000003, 64'h00000001
  };

  logic [23:0] coef [4];
  gimbal_cmd_t expected_cmds [$];

  assign pending_cmds = expected_cmds.size();

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // vectoring cordic, full turn = 2^32, >>> floors on signed values
  function automatic longint vec_angle(longint xv, longint yv);
    longint ang, t, dx, dy;
    ang = 0;
    if (xv < 0) begin
      t = xv;
      if (yv >= 0) begin
        xv = yv; yv = -t; ang = 64'sd1073741824;
      end else begin
        xv = -yv; yv = t; ang = -64'sd1073741824;
      end
    end
    for (int i = 0; i < 30; i++) begin
      dx = xv >>> i;
      dy = yv >>> i;
      if (yv > 0) begin
        xv += dy; yv -= dx; ang += ATAN_STEP[i];
      end else begin
        xv -= dy; yv += dx; ang -= ATAN_STEP[i];
      end
    end
    return ang;
  endfunction

  function automatic longint angle_cmd(longint ang);
    longint c;
    c = (ang + 32768) >>> 16;
    if (c > 32767) c = 32767;
    if (c < -32768) c = -32768;
    return c;
  endfunction

  function automatic gimbal_cmd_t predict_cmd(logic [1:0] rotor, logic [71:0] d);
    longint x, y, z, r, inner, outer;
    longint unsigned syz, len, thr, k;
    gimbal_cmd_t c;
    x = longint'($signed(d[23:0]));
    y = longint'($signed(d[47:24]));
    z = longint'($signed(d[71:48]));
    if (x < 0) x = 0;
    k = coef[rotor];
    syz = y * y + z * z;
    len = int_sqrt((syz + x * x) << 16);
    if (k == 0) thr = 65535;
    else begin
      thr = (len << 15) / k;
      if (thr > 65535) thr = 65535;
    end
    if (syz == 0) begin
      inner = 32767;
      outer = x > 0 ? 16384 : 0;
    end else begin
      r = longint'(int_sqrt(syz << 16));
      inner = angle_cmd(vec_angle(-z * 65536, y * 65536));
      outer = angle_cmd(vec_angle(r * 256, x * 65536));
      if (outer < -492) outer = -492;
    end
    c.thrust = thr[15:0];
    c.inner = inner[15:0];
    c.outer = outer[15:0];
    return c;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  initial fail_count = 0;

  always @(posedge clk) begin
    gimbal_cmd_t got, want;
    if (!rst_n) begin
      foreach (coef[i]) coef[i] <= 24'd65536;
    end else begin
      if (in_tvalid && in_tready) expected_cmds.push_back(predict_cmd(in_tuser, in_tdata));
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (expected_cmds.size() == 0) begin
          report_mismatch("unexpected word", out_tdata, 0);
        end else begin
          want = expected_cmds.pop_front();
          if (got.thrust != want.thrust) report_mismatch("thrust_cmd", got.thrust, want.thrust);
          if (got.inner != want.inner) report_mismatch("inner_cmd", got.inner, want.inner);
          if (got.outer != want.outer) report_mismatch("outer_cmd", got.outer, want.outer);
        end
      end
      if (cfg_wr_en) coef[cfg_index] <= cfg_data;
    end
  end

endmodule

/* test/tb.sv */
// testbench top for thrust_vector_to_gimbal_commands_top: drives force words,
// coefficient writes and output stalls; tvg_checker does the checking
// depends on tvg_pkg, the block and tvg_checker
module tb;
  import tvg_pkg::*;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [71:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [47:0] out_tdata;
  logic        cfg_wr_en = 0;
  logic [1:0]  cfg_index = REG_COEF0;
  logic [23:0] cfg_data = '0;
  int          fail_count, pending_cmds;
  int          send_idle_pct, recv_idle_pct;

  always #2 clk = ~clk;

  thrust_vector_to_gimbal_commands_top dut (.*);
  tvg_checker chk (.*);

  // receiver stall pattern, changed at the falling edge
  always @(negedge clk) out_tready <= ($urandom_range(99) >= recv_idle_pct);

  function automatic logic [23:0] rand_force();
    case ($urandom_range(5))
      0: return 24'(longint'($urandom_range(16)) - 8);
      1: return $urandom_range(1) ? 24'h7FFFFF : 24'h800000;
      2: return 24'($urandom_range(20000)) - 24'd10000;
      default: return 24'($urandom);
    endcase
  endfunction

  // valid stays high after a word so back to back words need no gap;
  // idle cycles and drain() take it low
  task automatic send_word(logic [1:0] rotor, logic [23:0] fx, logic [23:0] fy,
                           logic [23:0] fz);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 0;
      @(negedge clk);
    end
    in_tvalid <= 1;
    in_tuser <= rotor;
    in_tdata <= {fz, fy, fx};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 0;
    while (pending_cmds != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  task automatic write_coef(reg_idx_t idx, logic [23:0] val);
    cfg_wr_en <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_wr_en <= 0;
    @(negedge clk);
  endtask

  task automatic random_words(int n);
    for (int i = 0; i < n; i++) begin
      send_word(2'($urandom), rand_force(), rand_force(), rand_force());
      if (i == n / 2) drain();
    end
  endtask

  initial begin
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (11) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);
    // directed: extremes, negative x clamp, y=z=0, every rotor
    send_word(2'd0, 24'h0, 24'h0, 24'h0);
    send_word(2'd1, 24'h000100, 24'h0, 24'h0);
    send_word(2'd2, 24'hFFFF00, 24'h0, 24'h0);
    send_word(2'd3, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
    send_word(2'd0, 24'h800000, 24'h800000, 24'h800000);
    send_word(2'd1, 24'h0, 24'h000100, 24'h0);
    send_word(2'd2, 24'h0, 24'h0, 24'hFFFF00);
    send_word(2'd3, 24'h0, 24'h0, 24'h000100);
    send_word(2'd0, 24'h0, 24'hFFFF00, 24'h0);
    send_word(2'd1, 24'h0, 24'h000001, 24'h800000);
    send_word(2'd2, 24'h0, 24'hFFFFFF, 24'h7FFFFF);
    send_word(2'd3, 24'h000001, 24'h7FFFFF, 24'h0);
    send_word(2'd0, 24'h7FFFFF, 24'h0, 24'h000001);
    send_word(2'd1, 24'h800000, 24'h123456, 24'hABCDEF);
    send_word(2'd2, 24'h555555, 24'hAAAAAA, 24'h555555);
    drain();
    write_coef(REG_COEF0, 24'h0);
    write_coef(REG_COEF1, 24'hFFFFFF);
    write_coef(REG_COEF2, 24'h000001);
    write_coef(REG_COEF3, 24'h008000);
    for (int r = 0; r < 4; r++) send_word(2'(r), 24'h001000, 24'h7FFFFF, 24'h800000);
    drain();
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = phase == 0 ? 21 : phase == 1 ? 81 : 0;
      recv_idle_pct = phase == 0 ? 81 : phase == 1 ? 21 : 0;
      for (int r = 0; r < 4; r++) write_coef(reg_idx_t'(r), 24'($urandom));
      random_words(90);
      drain();
      for (int r = 0; r < 4; r++) write_coef(reg_idx_t'(r), 24'($urandom_range(200000)));
      random_words(185);
      drain();
    end
    if (fail_count == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

  initial begin
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
